FILE: hdl/lbc_pkg.sv
`default_nettype none

package lbc_pkg;

  localparam int CODE_W     = 16;  // codeword / row width
  localparam int MSG_W      = 6;   // message width
  localparam int ROW_COUNT  = 6;   // generator rows held
  localparam int ERR_W      = 5;   // weight width, 0..16
  localparam int K_W        = 3;   // message_bits register width
  localparam int N_W        = 5;   // code_bits register width
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // length clamps, tied to the datapath widths
  localparam int MAX_CODE_BITS    = CODE_W;
  localparam int MAX_MESSAGE_BITS = MSG_W;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_GEN_ROW5     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_BITS = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_BITS    = 3'd7;

  localparam logic [K_W-1:0] MESSAGE_BITS_RST = 3'd4;
  localparam logic [N_W-1:0] CODE_BITS_RST    = 5'd7;

  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } lbc_state_t;

  // verdict of the weight compare unit for one candidate
  typedef struct packed {
    logic             take;
    logic [ERR_W-1:0] weight;
  } cmp_res_t;

endpackage

`default_nettype wire

FILE: hdl/lbc_enc.sv
`default_nettype none

// Codeword for one message index: XOR of the generator rows it selects.
module lbc_enc import lbc_pkg::*; (
  input  wire logic [CODE_W-1:0] rows [ROW_COUNT],
  input  wire logic [K_W-1:0]    k_eff,
  input  wire logic [CODE_W-1:0] cmask,
  input  wire logic [MSG_W-1:0]  idx,
  output logic      [CODE_W-1:0] cw
);

  always_comb begin
    logic [CODE_W-1:0] acc;
    logic [K_W-1:0]    pos;
    acc = '0;
    pos = '0;
    for (int r = 0; r < ROW_COUNT; r++) begin
      // message bit k-1-r selects row r
      if (r < int'(k_eff)) begin
        pos = K_W'(int'(k_eff) - 1 - r);
        if (idx[pos]) begin
          acc = acc ^ rows[r];
        end
      end
    end
    cw = acc & cmask;
  end

endmodule

`default_nettype wire

FILE: hdl/lbc_wcmp.sv
`default_nettype none

// Weight of one candidate error pattern and compare against the best so far.
module lbc_wcmp import lbc_pkg::*; (
  input  wire logic [CODE_W-1:0] v,
  input  wire logic [CODE_W-1:0] best_v,
  input  wire logic [ERR_W-1:0]  best_w,
  input  wire logic              first,
  output cmp_res_t               res
);

  logic [1:0]       pair_sum [8];
  logic [2:0]       quad_sum [4];
  logic [3:0]       oct_sum  [2];
  logic [ERR_W-1:0] w;

  // popcount as an adder tree
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      pair_sum[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      quad_sum[i] = {1'b0, pair_sum[2*i]} + {1'b0, pair_sum[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      oct_sum[i] = {1'b0, quad_sum[2*i]} + {1'b0, quad_sum[2*i+1]};
    end
    w = {1'b0, oct_sum[0]} + {1'b0, oct_sum[1]};
  end

  // least weight wins, ties go to the smaller value
  assign res.weight = w;
  assign res.take   = first || (w < best_w) || ((w == best_w) && (v < best_v));

endmodule

`default_nettype wire

FILE: hdl/linear_block_code_standard_array_top.sv
`default_nettype none

// Channel  | Handshake          | Payload
// ---------+--------------------+----------------------------------------------
// input    | in_valid/in_stall  | in_opcode, in_message, in_received_word
// result   | out_valid/out_stall| out_codeword, out_errors_corrected
// config   | cfg_we             | cfg_index, cfg_data
//
// Encode forms the codeword of the message; decode makes one weight compare per
// codeword, 2^k of them with k the clamped message_bits, all in a single
// shared compare unit. Input is taken only while idle, never during an item.
// Synchronous active-low reset restores register defaults and empties the block.
// A waiting result sits in the output register while the next item runs; the
// final step holds only while that register is full and out_stall is high.
module linear_block_code_standard_array_top import lbc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_opcode,
  input  wire logic [MSG_W-1:0]      in_message,
  input  wire logic [CODE_W-1:0]     in_received_word,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [CODE_W-1:0]     out_codeword,
  output logic      [ERR_W-1:0]      out_errors_corrected
);

  logic [CODE_W-1:0] gen_rows_r [ROW_COUNT];
  logic [K_W-1:0]    msg_bits_r;
  logic [N_W-1:0]    code_bits_r;

  lbc_state_t        state_r, state_nxt;
  logic              op_r;
  logic [MSG_W-1:0]  msg_r;
  logic [CODE_W-1:0] rx_r;
  logic [MSG_W-1:0]  m_r, m_nxt;
  logic [CODE_W-1:0] best_v_r, best_v_nxt;
  logic [ERR_W-1:0]  best_w_r, best_w_nxt;

  logic              out_valid_r;
  logic [CODE_W-1:0] out_codeword_r;
  logic [ERR_W-1:0]  out_errors_r;

  logic [K_W-1:0]    k_eff;
  logic [N_W-1:0]    n_eff;
  logic [CODE_W-1:0] cmask;
  logic [MSG_W-1:0]  last_idx;
  logic [MSG_W-1:0]  enc_idx;
  logic [CODE_W-1:0] cw;
  logic [CODE_W-1:0] cand_v;
  cmp_res_t          cmp;
  logic              last;
  logic              out_free;
  logic              accept;
  logic              step;
  logic              finish;
  logic              advance;
  logic [CODE_W-1:0] fin_v;
  logic [ERR_W-1:0]  fin_w;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < ROW_COUNT; r++) begin
        gen_rows_r[r] <= '0;
      end
      msg_bits_r  <= MESSAGE_BITS_RST;
      code_bits_r <= CODE_BITS_RST;
    end else if (cfg_we) begin
      if (cfg_index <= CFG_GEN_ROW5) begin
        gen_rows_r[cfg_index] <= cfg_data;
      end else if (cfg_index == CFG_MESSAGE_BITS) begin
        msg_bits_r <= cfg_data[K_W-1:0];
      end else if (cfg_index == CFG_CODE_BITS) begin
        code_bits_r <= cfg_data[N_W-1:0];
      end
    end
  end

  // clamp lengths
  always_comb begin
    if (msg_bits_r == '0) begin
      k_eff = K_W'(1);
    end else if (int'(msg_bits_r) > MAX_MESSAGE_BITS) begin
      k_eff = K_W'(MAX_MESSAGE_BITS);
    end else begin
      k_eff = msg_bits_r;
    end
    if (code_bits_r == '0) begin
      n_eff = N_W'(1);
    end else if (int'(code_bits_r) > MAX_CODE_BITS) begin
      n_eff = N_W'(MAX_CODE_BITS);
    end else begin
      n_eff = code_bits_r;
    end
    for (int i = 0; i < CODE_W; i++) begin
      cmask[i] = (i < int'(n_eff));
    end
  end

  assign last_idx = MSG_W'((7'd1 << k_eff) - 7'd1);

  // shared datapath: codeword for the current index, then weight compare
  assign enc_idx = (op_r == OP_ENCODE) ? msg_r : m_r;

  lbc_enc u_enc (
    .rows  (gen_rows_r),
    .k_eff (k_eff),
    .cmask (cmask),
    .idx   (enc_idx),
    .cw    (cw)
  );

  assign cand_v = rx_r ^ cw;

  lbc_wcmp u_wcmp (
    .v      (cand_v),
    .best_v (best_v_r),
    .best_w (best_w_r),
    .first  (m_r == '0),
    .res    (cmp)
  );

  assign last     = (op_r == OP_ENCODE) || (m_r == last_idx);
  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (last && out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall = 1'b1;
    step     = 1'b0;
    case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_RUN:  step     = 1'b1;
      default: in_stall = 1'b1;
    endcase
  end

  assign accept  = in_valid && !in_stall;
  assign finish  = step && last && out_free;
  assign advance = step && !last;

  // best-so-far update
  always_comb begin
    m_nxt      = m_r;
    best_v_nxt = best_v_r;
    best_w_nxt = best_w_r;
    if (accept) begin
      m_nxt = '0;
    end else if (advance) begin
      m_nxt = m_r + MSG_W'(1);
      if (cmp.take) begin
        best_v_nxt = cand_v;
        best_w_nxt = cmp.weight;
      end
    end
  end

  assign fin_v = cmp.take ? cand_v : best_v_r;
  assign fin_w = cmp.take ? cmp.weight : best_w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r      <= m_nxt;
    best_v_r <= best_v_nxt;
    best_w_r <= best_w_nxt;
    if (accept) begin
      op_r  <= in_opcode;
      msg_r <= in_message;
      rx_r  <= in_received_word & cmask;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      if (op_r == OP_ENCODE) begin
        out_codeword_r <= cw;
        out_errors_r   <= '0;
      end else begin
        out_codeword_r <= rx_r ^ fin_v;
        out_errors_r   <= fin_w;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_codeword         = out_codeword_r;
  assign out_errors_corrected = out_errors_r;

endmodule

`default_nettype wire

FILE: verif/tb_linear_block_code_standard_array_top.sv
module tb_linear_block_code_standard_array_top import lbc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] CFG_GEN_ROW0 = 3'd0;
  localparam int QUIET_CYCLES = 4;
  localparam int TAIL_CYCLES  = 80;
  localparam int STALL_LIMIT  = 5000;
  localparam int RANDOM_SETS  = 17;
  localparam int JOBS_PER_HALF = 25;
  localparam int SHOW_LIMIT   = 10;

  typedef struct {
    logic             op;
    logic [MSG_W-1:0]  msg;
    logic [CODE_W-1:0] rx;
  } code_job_t;

  typedef struct {
    logic [CODE_W-1:0] cw;
    logic [ERR_W-1:0]  errs;
  } code_result_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_opcode = OP_ENCODE;
  logic [MSG_W-1:0]  in_message = '0;
  logic [CODE_W-1:0] in_received_word = '0;

  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CODE_W-1:0] out_codeword;
  logic [ERR_W-1:0]  out_errors_corrected;

  // local copy of the code registers
  logic [CODE_W-1:0] gen_rows [ROW_COUNT];
  logic [K_W-1:0]    msg_bits_reg = MESSAGE_BITS_RST;
  logic [N_W-1:0]    code_bits_reg = CODE_BITS_RST;
  logic [CODE_W-1:0] staged_rows [ROW_COUNT];

  code_job_t    code_jobs [$];
  code_result_t due_results [$];
  code_job_t    next_job;
  code_job_t    taken_job;
  code_result_t seen_result;

  int unsigned sender_gap_pct = 19;
  int unsigned receiver_gap_pct = 57;
  int unsigned fails = 0;
  int unsigned n_encodes = 0;
  int unsigned n_decodes = 0;
  int unsigned n_codes = 0;
  int unsigned idle_cycles = 0;

  linear_block_code_standard_array_top i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_opcode            (in_opcode),
    .in_message           (in_message),
    .in_received_word     (in_received_word),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_codeword         (out_codeword),
    .out_errors_corrected (out_errors_corrected)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned active_k();
    int unsigned k;
    k = msg_bits_reg;
    if (k < 1) k = 1;
    if (k > MSG_W) k = MSG_W;
    return k;
  endfunction

  function automatic int unsigned active_n();
    int unsigned n;
    n = code_bits_reg;
    if (n < 1) n = 1;
    if (n > CODE_W) n = CODE_W;
    return n;
  endfunction

  function automatic logic [CODE_W-1:0] code_mask();
    logic [CODE_W-1:0] mask;
    mask = '0;
    for (int i = 0; i < active_n(); i++) mask[i] = 1'b1;
    return mask;
  endfunction

  // message bit k-1-r selects generator row r
  function automatic logic [CODE_W-1:0] encode_message(input logic [MSG_W-1:0] msg);
    int unsigned k;
    logic [CODE_W-1:0] cw;
    k = active_k();
    cw = '0;
    for (int r = 0; r < k; r++)
      if (msg[k-1-r]) cw ^= gen_rows[r];
    return cw & code_mask();
  endfunction

  // least (weight, value) leader over all codewords, then strip it
  function automatic code_result_t nearest_codeword(input code_job_t job);
    code_result_t res;
    logic [CODE_W-1:0] rx, best, v;
    int unsigned best_w, w;
    if (job.op == OP_ENCODE) begin
      res.cw = encode_message(job.msg);
      res.errs = '0;
    end else begin
      rx = job.rx & code_mask();
      best = rx ^ encode_message('0);
      best_w = $countones(best);
      for (int m = 1; m < (1 << active_k()); m++) begin
        v = rx ^ encode_message(MSG_W'(m));
        w = $countones(v);
        if (w < best_w || (w == best_w && v < best)) begin
          best = v;
          best_w = w;
        end
      end
      res.cw = rx ^ best;
      res.errs = ERR_W'(best_w);
    end
    return res;
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        taken_job.op = in_opcode;
        taken_job.msg = in_message;
        taken_job.rx = in_received_word;
        due_results = {due_results, nearest_codeword(taken_job)};
        if (in_opcode == OP_ENCODE) n_encodes++;
        else n_decodes++;
      end
      // hold a stalled transfer, otherwise pick the next job or idle
      if (!in_valid || !in_stall) begin
        if (code_jobs.size() > 0 && $urandom_range(99) >= sender_gap_pct) begin
          next_job = code_jobs.pop_front();
          in_valid <= 1'b1;
          in_opcode <= next_job.op;
          in_message <= next_job.msg;
          in_received_word <= next_job.rx;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          fails++;
          if (fails <= SHOW_LIMIT)
            $display("unexpected result: codeword %h errors %0d",
                     out_codeword, out_errors_corrected);
        end else begin
          seen_result = due_results.pop_front();
          if (out_codeword !== seen_result.cw ||
              out_errors_corrected !== seen_result.errs) begin
            fails++;
            if (fails <= SHOW_LIMIT)
              $display("mismatch: codeword exp %h got %h, errors exp %0d got %0d",
                       seen_result.cw, out_codeword, seen_result.errs,
                       out_errors_corrected);
          end
        end
      end
      out_stall <= ($urandom_range(99) < receiver_gap_pct);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", idle_cycles);
        $display("linear_block_code_standard_array_top test failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic push_job(input logic op, input logic [MSG_W-1:0] msg,
                          input logic [CODE_W-1:0] rx);
    code_job_t job;
    job.op = op;
    job.msg = msg;
    job.rx = rx;
    code_jobs = {code_jobs, job};
  endtask

  task automatic wait_quiet();
    do @(posedge clk);
    while (!(code_jobs.size() == 0 && !in_valid && due_results.size() == 0));
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_MESSAGE_BITS: msg_bits_reg = data[K_W-1:0];
      CFG_CODE_BITS:    code_bits_reg = data[N_W-1:0];
      default:          gen_rows[idx - CFG_GEN_ROW0] = data;
    endcase
  endtask

  // write every register; the block must be quiet
  task automatic set_code(input logic [K_W-1:0] k, input logic [N_W-1:0] n);
    for (int r = 0; r < ROW_COUNT; r++)
      write_reg(CFG_GEN_ROW0 + CFG_IDX_W'(r), staged_rows[r]);
    write_reg(CFG_MESSAGE_BITS, CFG_DATA_W'(k));
    write_reg(CFG_CODE_BITS, CFG_DATA_W'(n));
    @(posedge clk);
    cfg_we <= 1'b0;
    n_codes++;
  endtask

  task automatic random_code();
    logic [K_W-1:0] k;
    logic [N_W-1:0] n;
    int unsigned kk;
    for (int r = 0; r < ROW_COUNT; r++) staged_rows[r] = CODE_W'($urandom);
    // now and then a rank-deficient generator
    if ($urandom_range(3) == 0)
      staged_rows[$urandom_range(ROW_COUNT-1)] = staged_rows[$urandom_range(ROW_COUNT-1)];
    if ($urandom_range(7) == 0) k = K_W'($urandom);
    else k = K_W'($urandom_range(1, MSG_W));
    kk = (k < 1) ? 1 : (k > MSG_W) ? MSG_W : k;
    if ($urandom_range(5) == 0) n = N_W'($urandom);
    else n = N_W'($urandom_range(kk, CODE_W));
    set_code(k, n);
  endtask

  // random encodes and decodes; decode words are mostly near-codewords with a few flipped bits, some plain noise
  task automatic queue_random_jobs(input int count);
    logic [CODE_W-1:0] rx;
    int unsigned nerr;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(1) == 0) begin
        push_job(OP_ENCODE, MSG_W'($urandom), CODE_W'($urandom));
      end else begin
        if ($urandom_range(2) == 0) begin
          rx = CODE_W'($urandom);
        end else begin
          rx = encode_message(MSG_W'($urandom));
          nerr = $urandom_range(3);
          for (int e = 0; e < nerr; e++) rx[$urandom_range(active_n() - 1)] ^= 1'b1;
          if ($urandom_range(3) == 0) rx |= CODE_W'($urandom) & ~code_mask();
        end
        push_job(OP_DECODE, MSG_W'($urandom), rx);
      end
    end
  endtask

  initial begin
    for (int r = 0; r < ROW_COUNT; r++) begin
      gen_rows[r] = '0;
      staged_rows[r] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: all-zero generator, k=4, n=7
    push_job(OP_ENCODE, 6'h3F, 16'h0000);
    push_job(OP_DECODE, 6'h00, 16'hFFFF);
    push_job(OP_DECODE, 6'h3F, 16'h0000);
    wait_quiet();

    // Hamming (7,4) in systematic form
    staged_rows[0] = 16'h0046;
    staged_rows[1] = 16'h0023;
    staged_rows[2] = 16'h0017;
    staged_rows[3] = 16'h000D;
    staged_rows[4] = 16'hFFFF;
    staged_rows[5] = 16'hFFFF;
    set_code(3'd4, 5'd7);
    push_job(OP_ENCODE, 6'h00, 16'hFFFF);
    push_job(OP_ENCODE, 6'h0F, 16'h0000);
    push_job(OP_ENCODE, 6'h3F, 16'h0000);
    push_job(OP_ENCODE, 6'h0A, 16'h0000);
    push_job(OP_DECODE, 6'h00, 16'h0051);
    push_job(OP_DECODE, 6'h00, 16'h0050);
    push_job(OP_DECODE, 6'h00, 16'h0011);
    push_job(OP_DECODE, 6'h00, 16'h0052);
    push_job(OP_DECODE, 6'h00, 16'hFFFF);
    push_job(OP_DECODE, 6'h00, 16'hFF80);
    wait_quiet();

    // message_bits and code_bits above range clamp to 6 and 16
    for (int r = 0; r < ROW_COUNT; r++) staged_rows[r] = CODE_W'($urandom);
    set_code(3'd7, 5'd31);
    push_job(OP_ENCODE, 6'h3F, 16'h0000);
    push_job(OP_DECODE, 6'h00, 16'hFFFF);
    push_job(OP_DECODE, 6'h00, 16'h0001);
    wait_quiet();

    // zero lengths clamp to 1
    staged_rows[0] = 16'hFFFF;
    set_code(3'd0, 5'd0);
    push_job(OP_ENCODE, 6'h01, 16'h0000);
    push_job(OP_DECODE, 6'h00, 16'h0001);
    push_job(OP_DECODE, 6'h3F, 16'hFFFE);
    wait_quiet();

    // code shorter than the message
    for (int r = 0; r < ROW_COUNT; r++) staged_rows[r] = CODE_W'($urandom);
    set_code(3'd6, 5'd3);
    push_job(OP_ENCODE, 6'h2A, 16'h0000);
    push_job(OP_DECODE, 6'h00, 16'h0005);
    wait_quiet();

    // rank-deficient generator: three equal rows
    staged_rows[0] = 16'h00F0;
    staged_rows[1] = 16'h00F0;
    staged_rows[2] = 16'h00F0;
    set_code(3'd3, 5'd8);
    push_job(OP_DECODE, 6'h00, 16'h00F3);
    push_job(OP_ENCODE, 6'h07, 16'h0000);
    wait_quiet();

    for (int s = 0; s < RANDOM_SETS; s++) begin
      if (s < RANDOM_SETS / 3) begin
        sender_gap_pct = 19;
        receiver_gap_pct = 57;
      end else if (s < 2 * RANDOM_SETS / 3) begin
        sender_gap_pct = 57;
        receiver_gap_pct = 19;
      end else begin
        sender_gap_pct = 0;
        receiver_gap_pct = 0;
      end
      random_code();
      queue_random_jobs(JOBS_PER_HALF);
      // hold the sender until every result of the first half is back
      wait_quiet();
      queue_random_jobs(JOBS_PER_HALF);
      wait_quiet();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (due_results.size() != 0) fails++;

    $display("covered %0d encodes and %0d decodes over %0d code settings",
             n_encodes, n_decodes, n_codes);
    $display("including clamped lengths, short codes and rank-deficient generators");
    if (fails == 0) begin
      $display("linear_block_code_standard_array_top test passed");
    end else begin
      $display("%0d failures", fails);
      $display("linear_block_code_standard_array_top test failed");
    end
    $finish;
  end

endmodule
